// ===== hdl/spatial_distance_attenuation_defines.svh =====
// Assertion macros for the spatial distance attenuation checker.
// No dependencies; included by the checker file only.
`ifndef SPATIAL_DISTANCE_ATTENUATION_DEFINES_SVH
`define SPATIAL_DISTANCE_ATTENUATION_DEFINES_SVH

// clocked assertion with synchronous active-low reset as disable
`define SDA_ASSERT_CR(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("spatial_distance_attenuation: assertion failed");

// same, on the block's clk and rst_n
`define SDA_ASSERT(lbl, prop) `SDA_ASSERT_CR(lbl, clk, rst_n, prop)

`endif

// ===== hdl/sda_pkg.sv =====
// Package for the spatial distance attenuation block: widths, stage map, codes.
// No dependencies.
`default_nettype none
package sda_pkg;
  localparam int POS_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int DIST_W   = 24;
  localparam int DIFF_W   = POS_W + 1;
  // coordinate difference magnitude is clamped to 2^25
  localparam int MAG_W    = 26;
  localparam int MAGX_W   = (DIFF_W > MAG_W) ? DIFF_W : MAG_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int PROD_W   = GAIN_W + DIST_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Z = 2'd2;

  localparam logic [1:0] SEL_VOL  = 2'd0;
  localparam logic [1:0] SEL_ZERO = 2'd1;
  localparam logic [1:0] SEL_DIV  = 2'd2;

  // stage map
  localparam int S_MAG = 0;
  localparam int S_SQ  = 1;
  localparam int S_SUM = 2;
  localparam int S_RT0 = 3;
  localparam int S_CLS = S_RT0 + ROOT_W;
  localparam int S_MUL = S_CLS + 1;
  localparam int S_DV0 = S_MUL + 1;
  localparam int S_OUT = S_DV0 + GAIN_W;
  localparam int NST   = S_OUT + 1;
  localparam int LATENCY = NST;

  typedef struct packed {
    logic [GAIN_W-1:0] vol;
    logic [DIST_W-1:0] near_d;
    logic [DIST_W-1:0] far_d;
    logic              spatial;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  x;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } rt_t;

  typedef struct packed {
    logic [DIST_W-1:0] rem;
    logic [GAIN_W-1:0] low;
    logic [GAIN_W-1:0] q;
  } dv_t;
endpackage
`default_nettype wire

// ===== hdl/spatial_distance_attenuation.sv =====
// One voice per cycle is accepted on start; results leave in order on out_valid.
// busy is always low: the datapath is a fully pipelined square-root line (one
// root bit per stage) and a restoring divider line (one quotient bit per stage).
// The receiver cannot stall.
// Synchronous active-low reset clears all valid bits and zeroes the listener.
// Depends on sda_pkg.
`default_nettype none
module spatial_distance_attenuation import sda_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [POS_W-1:0]     in_source_x,
  input  wire logic [POS_W-1:0]     in_source_y,
  input  wire logic [POS_W-1:0]     in_source_z,
  input  wire logic [GAIN_W-1:0]    in_volume,
  input  wire logic [DIST_W-1:0]    in_near_distance,
  input  wire logic [DIST_W-1:0]    in_far_distance,
  input  wire logic                 in_is_spatial,
  output logic                      out_valid,
  output logic [GAIN_W-1:0]         out_gain,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [POS_W-1:0]     cfg_data
);

  logic [POS_W-1:0] lis_r [3];
  logic             vld_r [NST];
  item_t            pl_r  [S_OUT];

  logic [MAG_W-1:0]  mag_r [3], mag_nxt [3];
  logic [SQ_W-1:0]   sq_r  [3];
  logic [SUM_W-1:0]  sum_r;
  rt_t               rt_r  [ROOT_W], rt_nxt [ROOT_W];
  logic [1:0]        sel_r [GAIN_W+2];
  logic [1:0]        sel_nxt;
  logic [DIST_W-1:0] numb_r, numb_nxt;
  logic [DIST_W-1:0] den_r  [GAIN_W+1];
  logic [DIST_W-1:0] den_nxt;
  logic [PROD_W-1:0] prod_r;
  dv_t               dv_r   [GAIN_W], dv_nxt [GAIN_W];
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic              acc;
  item_t             in_item;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign in_item = '{vol: in_volume, near_d: in_near_distance,
                     far_d: in_far_distance, spatial: in_is_spatial};

  function automatic logic [MAG_W-1:0] clamp_mag(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] m;
    logic [MAGX_W-1:0] mx;
    logic [MAGX_W-1:0] lim;
    d   = {a[POS_W-1], a} - {b[POS_W-1], b};
    m   = d[DIFF_W-1] ? (~d + 1'b1) : d;
    mx  = MAGX_W'(m);
    lim = MAGX_W'(1) << (MAG_W - 1);
    if (mx > lim) mx = lim;
    return mx[MAG_W-1:0];
  endfunction

  // one bit of the digit-by-digit square root
  function automatic rt_t rt_step(input rt_t s);
    rt_t               o;
    logic [REM_W-1:0]  r;
    logic [REM_W-1:0]  t;
    r = {s.rem[REM_W-3:0], s.x[SUM_W-1 -: 2]};
    t = {s.root, 2'b01};
    o.x = {s.x[SUM_W-3:0], 2'b00};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one bit of restoring division; remainder stays below den
  function automatic dv_t dv_step(input dv_t s, input logic [DIST_W-1:0] den);
    dv_t             o;
    logic [DIST_W:0] r;
    r = {s.rem, s.low[GAIN_W-1]};
    o.low = {s.low[GAIN_W-2:0], 1'b0};
    if (r >= {1'b0, den}) begin
      r   = r - {1'b0, den};
      o.q = {s.q[GAIN_W-2:0], 1'b1};
    end else begin
      o.q = {s.q[GAIN_W-2:0], 1'b0};
    end
    o.rem = r[DIST_W-1:0];
    return o;
  endfunction

  always_comb begin
    rt_t               s0;
    logic [ROOT_W-1:0] root_d;
    logic [ROOT_W-1:0] near_x;
    logic [ROOT_W-1:0] far_x;
    item_t             pc;
    dv_t               d0;
    mag_nxt[0] = clamp_mag(in_source_x, lis_r[0]);
    mag_nxt[1] = clamp_mag(in_source_y, lis_r[1]);
    mag_nxt[2] = clamp_mag(in_source_z, lis_r[2]);

    s0 = '{x: sum_r, root: '0, rem: '0};
    for (int i = 0; i < ROOT_W; i++) begin
      rt_nxt[i] = rt_step((i == 0) ? s0 : rt_r[(i == 0) ? 0 : i - 1]);
    end

    pc     = pl_r[S_CLS-1];
    root_d = rt_r[ROOT_W-1].root;
    near_x = ROOT_W'(pc.near_d);
    far_x  = ROOT_W'(pc.far_d);
    priority if (!pc.spatial || root_d <= near_x) sel_nxt = SEL_VOL;
    else if (root_d >= far_x)                      sel_nxt = SEL_ZERO;
    else                                            sel_nxt = SEL_DIV;
    numb_nxt = pc.far_d - root_d[DIST_W-1:0];
    den_nxt  = pc.far_d - pc.near_d;

    d0 = '{rem: prod_r[PROD_W-1:GAIN_W], low: prod_r[GAIN_W-1:0], q: '0};
    for (int i = 0; i < GAIN_W; i++) begin
      dv_nxt[i] = dv_step((i == 0) ? d0 : dv_r[(i == 0) ? 0 : i - 1], den_r[i+1]);
    end

    unique case (sel_r[GAIN_W+1])
      SEL_VOL:  gain_nxt = pl_r[S_OUT-1].vol;
      SEL_DIV:  gain_nxt = dv_r[GAIN_W-1].q;
      default:  gain_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) lis_r[i] <= '0;
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_LISTENER_X: lis_r[0] <= cfg_data;
          CFG_LISTENER_Y: lis_r[1] <= cfg_data;
          CFG_LISTENER_Z: lis_r[2] <= cfg_data;
          default: ;
        endcase
      end
      vld_r[0] <= acc;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pl_r[0] <= in_item;
    for (int i = 1; i < S_OUT; i++) pl_r[i] <= pl_r[i-1];
    for (int i = 0; i < 3; i++) begin
      mag_r[i] <= mag_nxt[i];
      sq_r[i]  <= mag_r[i] * mag_r[i];
    end
    sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    for (int i = 0; i < ROOT_W; i++) rt_r[i] <= rt_nxt[i];
    sel_r[0]  <= sel_nxt;
    den_r[0]  <= den_nxt;
    numb_r    <= numb_nxt;
    for (int i = 1; i < GAIN_W + 2; i++) sel_r[i] <= sel_r[i-1];
    for (int i = 1; i < GAIN_W + 1; i++) den_r[i] <= den_r[i-1];
    prod_r <= PROD_W'(pl_r[S_MUL-1].vol) * PROD_W'(numb_r);
    for (int i = 0; i < GAIN_W; i++) dv_r[i] <= dv_nxt[i];
    gain_r <= gain_nxt;
  end

  assign out_valid = vld_r[S_OUT];
  assign out_gain  = gain_r;

endmodule
`default_nettype wire

// ===== hdl/sda_checker.sv =====
// Port-level checker for spatial_distance_attenuation, with its bind.
// Depends on sda_pkg and spatial_distance_attenuation_defines.svh.
`default_nettype none
`include "spatial_distance_attenuation_defines.svh"
module sda_checker import sda_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [GAIN_W-1:0] in_volume,
  input wire logic              in_is_spatial,
  input wire logic              out_valid,
  input wire logic [GAIN_W-1:0] out_gain
);
  logic acc;
  assign acc = start && !busy && rst_n;

  `SDA_ASSERT(a_never_busy, !busy)
  `SDA_ASSERT(a_beat_out, acc |-> ##LATENCY out_valid)
  `SDA_ASSERT(a_no_spurious, out_valid |-> $past(acc, LATENCY))
  `SDA_ASSERT(a_pass_vol, (acc && !in_is_spatial) |-> ##LATENCY (out_gain == $past(in_volume, LATENCY)))
endmodule

bind spatial_distance_attenuation sda_checker u_sda_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_volume(in_volume), .in_is_spatial(in_is_spatial),
  .out_valid(out_valid), .out_gain(out_gain)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for spatial_distance_attenuation: a local gain predictor
// checks every out_valid beat in order. Depends on sda_pkg and the block RTL.
`timescale 1ns / 1ps
module tb;
  import sda_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [POS_W-1:0] in_source_x, in_source_y, in_source_z;
  logic [GAIN_W-1:0] in_volume;
  logic [DIST_W-1:0] in_near_distance, in_far_distance;
  logic in_is_spatial;
  logic out_valid;
  logic [GAIN_W-1:0] out_gain;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [POS_W-1:0] cfg_data;

  spatial_distance_attenuation u_top (.*);

  logic signed [POS_W-1:0] lis_x, lis_y, lis_z;
  logic [GAIN_W-1:0] gain_q[$];
  int mismatches;
  int busy_pct;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] clamped_sq(logic signed [POS_W-1:0] a,
                                             logic signed [POS_W-1:0] b);
    longint d;
    longint m;
    d = longint'(a) - longint'(b);
    m = (d < 0) ? -d : d;
    if (m > (64'd1 << 25)) m = 64'd1 << 25;
    return m * m;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [GAIN_W-1:0] attenuated_gain(
      logic signed [POS_W-1:0] sx, logic signed [POS_W-1:0] sy,
      logic signed [POS_W-1:0] sz, logic [GAIN_W-1:0] vol,
      logic [DIST_W-1:0] nd, logic [DIST_W-1:0] fd, logic sp);
    logic [63:0] root_d;
    if (!sp) return vol;
    root_d = floor_root(clamped_sq(sx, lis_x) + clamped_sq(sy, lis_y)
                        + clamped_sq(sz, lis_z));
    if (root_d <= nd) return vol;
    if (root_d >= fd) return '0;
    return GAIN_W'((64'(vol) * (64'(fd) - root_d)) / (64'(fd) - 64'(nd)));
  endfunction

  // cfg_we stays high across back-to-back writes; set_listener drops it
  task automatic write_listener(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      CFG_LISTENER_X: lis_x = val;
      CFG_LISTENER_Y: lis_y = val;
      CFG_LISTENER_Z: lis_z = val;
      default: ;
    endcase
  endtask

  // start stays high between back-to-back beats; idling and drain drop it
  task automatic send_voice(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                            logic [POS_W-1:0] sz, logic [GAIN_W-1:0] vol,
                            logic [DIST_W-1:0] nd, logic [DIST_W-1:0] fd,
                            logic sp);
    while ($urandom_range(99) < busy_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_source_x <= sx;
    in_source_y <= sy;
    in_source_z <= sz;
    in_volume <= vol;
    in_near_distance <= nd;
    in_far_distance <= fd;
    in_is_spatial <= sp;
    @(posedge clk);
    while (busy) @(posedge clk);
    gain_q = {gain_q, attenuated_gain(sx, sy, sz, vol, nd, fd, sp)};
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (gain_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic set_listener(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                              logic [POS_W-1:0] z);
    drain();
    write_listener(CFG_LISTENER_X, x);
    write_listener(CFG_LISTENER_Y, y);
    write_listener(CFG_LISTENER_Z, z);
    cfg_we <= 0;
  endtask

  task automatic test_directed();
    send_voice(24'h7fffff, 24'h800000, 0, 16'hffff, 0, 24'hffffff, 0);
    send_voice(0, 0, 0, 16'hffff, 0, 0, 1);
    send_voice(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff, 0, 24'hffffff, 1);
    send_voice(24'h800000, 24'h800000, 24'h800000, 16'hffff, 0, 24'hffffff, 1);
    send_voice(24'h300, 24'h400, 0, 16'h8000, 24'h100, 24'hb00, 1);
    send_voice(24'h300, 24'h400, 0, 16'h8000, 24'h500, 24'hb00, 1);
    send_voice(24'h300, 24'h400, 0, 16'h8000, 24'h100, 24'h500, 1);
    // near not below far
    send_voice(24'h300, 24'h400, 0, 16'h1234, 24'h800, 24'h200, 1);
    send_voice(24'h300, 24'h400, 0, 16'h1234, 24'h400, 24'h200, 1);
    send_voice(24'h300, 24'h400, 0, 16'h1234, 24'h600, 24'h600, 1);
    send_voice(24'h1000, 0, 0, 16'hffff, 24'hfff, 24'h1001, 1);
    send_voice(24'h1000, 0, 0, 0, 0, 24'hffffff, 1);
    send_voice(24'h555555, 24'haaaaaa, 24'h123456, 16'haaaa, 24'hffffff, 24'hffffff, 1);
  endtask

  task automatic test_random(int n);
    logic [POS_W-1:0] sx, sy, sz;
    logic [DIST_W-1:0] nd, fd;
    logic [31:0] span;
    for (int i = 0; i < n; i++) begin
      span = 1 << $urandom_range(23, 4);
      sx = lis_x + POS_W'($urandom_range(span) - span / 2);
      sy = lis_y + POS_W'($urandom_range(span) - span / 2);
      sz = lis_z + POS_W'($urandom_range(span) - span / 2);
      if ($urandom_range(9) == 0) begin
        sx = POS_W'($urandom);
        sy = POS_W'($urandom);
        sz = POS_W'($urandom);
      end
      nd = DIST_W'($urandom_range(span));
      fd = nd + DIST_W'($urandom_range(2 * span));
      if ($urandom_range(9) == 0) begin
        nd = DIST_W'($urandom);
        fd = DIST_W'($urandom);
      end
      send_voice(sx, sy, sz, GAIN_W'($urandom), nd, fd, $urandom_range(7) != 0);
    end
  endtask

  // results cannot be held off; compare every strobe beat
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (gain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: gain %h", out_gain);
      end else begin
        if (out_gain !== gain_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("gain mismatch: expected %h actual %h", gain_q[0], out_gain);
        end
        void'(gain_q.pop_front());
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    mismatches = 0;
    busy_pct = 26;
    rst_n = 0;
    start = 0;
    cfg_we = 0;
    cfg_idx = CFG_LISTENER_X;
    cfg_data = 0;
    in_source_x = 0;
    in_source_y = 0;
    in_source_z = 0;
    in_volume = 0;
    in_near_distance = 0;
    in_far_distance = 0;
    in_is_spatial = 0;
    lis_x = 0;
    lis_y = 0;
    lis_z = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(300);
    set_listener(24'h7fffff, 24'h800000, 24'h7fffff);
    test_directed();
    test_random(300);
    set_listener(24'h800000, 24'h7fffff, 24'h800000);
    test_random(300);
    // no idling for a long stretch
    busy_pct = 0;
    set_listener(24'h012345, 24'hfedcba, 24'h000100);
    test_random(300);
    drain();
    if (gain_q.size() == 0 && mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== spatial_distance_attenuation.f =====
+incdir+hdl
hdl/sda_pkg.sv
hdl/spatial_distance_attenuation.sv
hdl/sda_checker.sv
tb/tb.sv
